>>> hw/rtl/epcd_pkg.sv
package epcd_pkg;

   // fixed field widths
   localparam int SAMPLE_W = 32;
   localparam int DER_W    = 48;
   localparam int SCALE_W  = 32;
   localparam int FRAC_W   = 16;
   localparam int PROD_W   = 2 * SCALE_W;

   // delay line and edge handling
   localparam int TAPS = 8;
   localparam int EDGE = 4;

   // stencil weights, applied to the paired differences
   localparam int COEF_OUTER = 3;
   localparam int COEF_THIRD = 32;
   localparam int COEF_INNER = 168;
   localparam int COEF_NEAR  = 672;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd65536;
   localparam logic [PROD_W-1:0]  ROUND_BIAS  = 64'd32768;
   localparam logic [DER_W:0]     POS_LIMIT   = 49'h0_7FFF_FFFF_FFFF;
   localparam logic [DER_W:0]     NEG_LIMIT   = 49'h0_8000_0000_0000;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       is_last;
   } req_type;

   typedef struct packed {
      logic signed [DER_W-1:0] derivative;
      logic                    clipped;
      logic                    last_result;
   } rsp_type;

   // per transaction control carried down the pipeline
   typedef struct packed {
      logic       has_deriv;
      logic       do_calc;
      logic [2:0] zeros;
   } ctl_type;

   // rounded and saturated scaling result
   typedef struct packed {
      logic signed [DER_W-1:0] derivative;
      logic                    clipped;
   } scale_res_type;

endpackage

>>> hw/rtl/epcd_round.sv
module epcd_round (
   input  logic [epcd_pkg::PROD_W-1:0] p_hi,
   input  logic [epcd_pkg::PROD_W-1:0] p_lo,
   input  logic                        neg,
   output epcd_pkg::scale_res_type     result
);

   logic [epcd_pkg::PROD_W-1:0] rounded;
   logic [epcd_pkg::DER_W-1:0]  low_part;
   logic [epcd_pkg::DER_W:0]    mag;
   logic [epcd_pkg::DER_W:0]    limit;
   logic                        over;
   logic                        clip;
   logic [epcd_pkg::DER_W-1:0]  mag_sat;

   // round the low product to nearest, ties away from zero on the magnitude
   assign rounded  = p_lo + epcd_pkg::ROUND_BIAS;
   assign low_part = rounded[epcd_pkg::PROD_W-1:epcd_pkg::FRAC_W];

   // high product beyond 31 bits is at least 2^47 and is always flagged as overflow
   assign over = |p_hi[epcd_pkg::PROD_W-1:31];
   assign mag  = {2'b00, p_hi[30:0], {epcd_pkg::FRAC_W{1'b0}}}
                 + {1'b0, low_part};

   // saturate and restore the sign
   assign limit   = neg ? epcd_pkg::NEG_LIMIT : epcd_pkg::POS_LIMIT;
   assign clip    = over || (mag > limit);
   assign mag_sat = clip ? limit[epcd_pkg::DER_W-1:0] : mag[epcd_pkg::DER_W-1:0];

   assign result.derivative = neg ? -mag_sat : mag_sat;
   assign result.clipped    = clip;

endmodule

>>> hw/rtl/eight_point_central_differentiator.sv
// channel  | ports                              | moves
// ---------+------------------------------------+-------------------------------
// request  | req_valid, req_ready, req_payload  | one sample and its is_last flag
// response | rsp_valid, rsp_ready, rsp_payload  | one derivative with flags
// csr      | csr_wr_en, csr_wr_data             | reciprocal_scale, no wait
//
// one request transaction per cycle while req_ready is high; rsp_valid is registered
// the is_last transaction gives up to five responses, back to back unless stalled;
// the output register emits the trailing zeros and holds the pipeline meanwhile
// three pipeline stages (differences, stencil sum, products) and the output register
// a stalled response fills the stages, then req_ready drops
// synchronous active high reset clears the delay line, counters and valid bits
module eight_point_central_differentiator #(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  epcd_pkg::req_type     req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output epcd_pkg::rsp_type     rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [31:0]           csr_wr_data
);

   localparam int DW = SAMPLE_BITS + 1;
   localparam int SW = SAMPLE_BITS + 11;
   localparam int HW = epcd_pkg::SCALE_W;

   localparam logic signed [SW-1:0] K_OUTER = SW'(epcd_pkg::COEF_OUTER);
   localparam logic signed [SW-1:0] K_THIRD = SW'(epcd_pkg::COEF_THIRD);
   localparam logic signed [SW-1:0] K_INNER = SW'(epcd_pkg::COEF_INNER);
   localparam logic signed [SW-1:0] K_NEAR  = SW'(epcd_pkg::COEF_NEAR);

   logic                           req_fire;
   logic signed [SAMPLE_BITS-1:0]  sample_x;

   logic [epcd_pkg::SCALE_W-1:0]   scale_ff;
   logic signed [SAMPLE_BITS-1:0]  history_ff [epcd_pkg::TAPS];
   logic signed [SAMPLE_BITS-1:0]  history_in [epcd_pkg::TAPS];
   logic [3:0]                     seen_ff;
   logic [3:0]                     seen_in;

   epcd_pkg::ctl_type              ctl_new;
   logic                           item_valid;

   logic                           s1_valid_ff;
   epcd_pkg::ctl_type              s1_ctl_ff;
   logic signed [DW-1:0]           s1_diff_ff [4];
   logic signed [DW-1:0]           s1_diff_in [4];

   logic                           s2_valid_ff;
   epcd_pkg::ctl_type              s2_ctl_ff;
   logic signed [SW-1:0]           s2_sum_ff;
   logic signed [SW-1:0]           s2_sum_in;

   logic                           s3_valid_ff;
   epcd_pkg::ctl_type              s3_ctl_ff;
   logic [epcd_pkg::PROD_W-1:0]    s3_p_hi_ff;
   logic [epcd_pkg::PROD_W-1:0]    s3_p_lo_ff;
   logic                           s3_neg_ff;
   logic                           sum_neg;
   logic [SW-1:0]                  sum_mag;
   logic [epcd_pkg::PROD_W-1:0]    mag_wide;
   logic [HW-1:0]                  mag_hi;
   logic [HW-1:0]                  mag_lo;

   logic                           s1_adv;
   logic                           s2_adv;
   logic                           s3_adv;
   logic                           s3_take;
   logic                           out_free;

   epcd_pkg::scale_res_type        scaled;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   epcd_pkg::rsp_type              rsp_ff;
   epcd_pkg::rsp_type              rsp_in;
   logic [2:0]                     zcnt_ff;
   logic [2:0]                     zcnt_in;

   // pipeline flow
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s3_take  = s3_valid_ff && out_free && (zcnt_ff == 3'd0);
   assign s3_adv   = !s3_valid_ff || s3_take;
   assign s2_adv   = !s2_valid_ff || s3_adv;
   assign s1_adv   = !s1_valid_ff || s2_adv;
   assign req_ready = s1_adv;
   assign req_fire  = req_valid && req_ready;

   // low SAMPLE_BITS bits of the sample field as a two's complement value; wider widths zero-extend it
   if (SAMPLE_BITS > epcd_pkg::SAMPLE_W) begin : g_wide
      assign sample_x = {{(SAMPLE_BITS - epcd_pkg::SAMPLE_W){1'b0}}, req_payload.sample};
   end else begin : g_narrow
      assign sample_x = req_payload.sample[SAMPLE_BITS-1:0];
   end

   // scale register
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= epcd_pkg::SCALE_RESET;
      end else if (csr_wr_en) begin
         scale_ff <= csr_wr_data;
      end
   end

   // delay line and sample count
   always_comb begin
      history_in = history_ff;
      seen_in    = seen_ff;
      if (req_fire) begin
         if (req_payload.is_last) begin
            for (int i = 0; i < epcd_pkg::TAPS; i++) begin
               history_in[i] = '0;
            end
            seen_in = '0;
         end else begin
            history_in[0] = sample_x;
            for (int i = 1; i < epcd_pkg::TAPS; i++) begin
               history_in[i] = history_ff[i-1];
            end
            if (seen_ff != 4'hF) begin
               seen_in = seen_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < epcd_pkg::TAPS; i++) begin
            history_ff[i] <= '0;
         end
         seen_ff <= '0;
      end else begin
         history_ff <= history_in;
         seen_ff    <= seen_in;
      end
   end

   // what the transaction produces: a centre result once four samples are in,
   // trailing zeros on the last one
   always_comb begin
      ctl_new.has_deriv = seen_ff >= 4'(epcd_pkg::EDGE);
      ctl_new.do_calc   = seen_ff >= 4'(2 * epcd_pkg::EDGE);
      if (!req_payload.is_last) begin
         ctl_new.zeros = 3'd0;
      end else if (ctl_new.has_deriv) begin
         ctl_new.zeros = 3'(epcd_pkg::EDGE);
      end else begin
         ctl_new.zeros = 3'(seen_ff[1:0]) + 3'd1;
      end
      item_valid = ctl_new.has_deriv || req_payload.is_last;
   end

   // stage 1: symmetric differences of the stencil
   assign s1_diff_in[0] = DW'(history_ff[7]) - DW'(sample_x);
   assign s1_diff_in[1] = DW'(history_ff[6]) - DW'(history_ff[0]);
   assign s1_diff_in[2] = DW'(history_ff[5]) - DW'(history_ff[1]);
   assign s1_diff_in[3] = DW'(history_ff[4]) - DW'(history_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_valid_ff <= req_fire && item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && req_fire) begin
         s1_ctl_ff  <= ctl_new;
         s1_diff_ff <= s1_diff_in;
      end
   end

   // stage 2: weighted sum
   assign s2_sum_in = K_OUTER * SW'(s1_diff_ff[0]) - K_THIRD * SW'(s1_diff_ff[1])
                    + K_INNER * SW'(s1_diff_ff[2]) - K_NEAR * SW'(s1_diff_ff[3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv && s1_valid_ff) begin
         s2_ctl_ff <= s1_ctl_ff;
         s2_sum_ff <= s2_sum_in;
      end
   end

   // stage 3: magnitude times scale, split in two 32 bit halves
   assign sum_neg  = s2_sum_ff[SW-1];
   assign sum_mag  = sum_neg ? -s2_sum_ff : s2_sum_ff;
   assign mag_wide = epcd_pkg::PROD_W'(sum_mag);
   assign mag_hi   = mag_wide[epcd_pkg::PROD_W-1:HW];
   assign mag_lo   = mag_wide[HW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_adv && s2_valid_ff) begin
         s3_ctl_ff  <= s2_ctl_ff;
         s3_neg_ff  <= sum_neg;
         s3_p_hi_ff <= epcd_pkg::PROD_W'(mag_hi) * epcd_pkg::PROD_W'(scale_ff);
         s3_p_lo_ff <= epcd_pkg::PROD_W'(mag_lo) * epcd_pkg::PROD_W'(scale_ff);
      end
   end

   // rounding and saturation
   epcd_round u_round (
      .p_hi   (s3_p_hi_ff),
      .p_lo   (s3_p_lo_ff),
      .neg    (s3_neg_ff),
      .result (scaled)
   );

   // output register: centre result first, then trailing zeros
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      zcnt_in      = zcnt_ff;
      if (out_free) begin
         rsp_valid_in = 1'b0;
         if (zcnt_ff != 3'd0) begin
            rsp_valid_in       = 1'b1;
            rsp_in.derivative  = '0;
            rsp_in.clipped     = 1'b0;
            rsp_in.last_result = zcnt_ff == 3'd1;
            zcnt_in            = zcnt_ff - 3'd1;
         end else if (s3_valid_ff) begin
            rsp_valid_in = 1'b1;
            if (s3_ctl_ff.has_deriv) begin
               rsp_in.derivative  = s3_ctl_ff.do_calc ? scaled.derivative : '0;
               rsp_in.clipped     = s3_ctl_ff.do_calc && scaled.clipped;
               rsp_in.last_result = 1'b0;
               zcnt_in            = s3_ctl_ff.zeros;
            end else begin
               rsp_in.derivative  = '0;
               rsp_in.clipped     = 1'b0;
               rsp_in.last_result = s3_ctl_ff.zeros == 3'd1;
               zcnt_in            = s3_ctl_ff.zeros - 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         zcnt_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         zcnt_ff      <= zcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // no stage 3 transaction moves while trailing zeros are still owed
   a_zeros_hold: assert property (@(posedge clock) disable iff (reset)
      (zcnt_ff != 3'd0) |-> !s3_take)
      else $error("stage 3 taken while trailing zeros pending");

   // a last transaction restarts the sequence count
   a_seq_restart: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.is_last) |=> (seen_ff == 4'd0))
      else $error("sample count not cleared after last transaction");

   // the final response of a sequence is always a plain zero
   a_last_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.last_result) |->
         (rsp_payload.derivative == '0 && !rsp_payload.clipped))
      else $error("last response not zero");

   // a saturated response is never zero
   a_clip_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.clipped) |-> (rsp_payload.derivative != '0))
      else $error("clipped response with zero value");

   // back pressure reaches the input only with every stage occupied
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff))
      else $error("request stalled with an empty stage");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int PIPE_SETTLE    = 12;
   localparam int WATCHDOG_LIMIT = 5000;

   localparam logic signed [epcd_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [epcd_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
   localparam logic [63:0] MAG_POS_LIMIT = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [63:0] MAG_NEG_LIMIT = 64'h0000_8000_0000_0000;
   localparam logic [63:0] HI_PRODUCT_LIMIT = 64'h0000_0000_8000_0000;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   epcd_pkg::req_type   req_payload = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   epcd_pkg::rsp_type   rsp_payload;
   logic                csr_wr_en   = 1'b0;
   logic [31:0]         csr_wr_data = '0;

   // idling controls, in percent
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // own copy of the block state
   logic [epcd_pkg::SCALE_W-1:0]         model_scale;
   logic signed [epcd_pkg::SAMPLE_W-1:0] model_history [epcd_pkg::TAPS];
   logic [3:0]                           model_seen;
   epcd_pkg::rsp_type                    pending_derivatives [$];

   int mismatches      = 0;
   int samples_sent    = 0;
   int sequences_done  = 0;
   int results_checked = 0;
   int scale_writes    = 0;
   int idle_cycles     = 0;

   eight_point_central_differentiator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at result %0d: %s got %0h expected %0h",
               results_checked, what, got, want);
      mismatches++;
   endtask

   // compare each response transaction with the oldest prediction
   always @(posedge clock) begin
      epcd_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_derivatives.size() == 0) begin
            report_mismatch("unexpected result", {14'd0, rsp_payload}, 64'd0);
         end else begin
            want = pending_derivatives.pop_front();
            if (rsp_payload.derivative !== want.derivative)
               report_mismatch("derivative", 64'(rsp_payload.derivative),
                               64'(want.derivative));
            if (rsp_payload.clipped !== want.clipped)
               report_mismatch("clipped", 64'(rsp_payload.clipped), 64'(want.clipped));
            if (rsp_payload.last_result !== want.last_result)
               report_mismatch("last_result", 64'(rsp_payload.last_result),
                               64'(want.last_result));
            results_checked++;
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding",
                  pending_derivatives.size());
         $display("eight_point_central_differentiator regression: fail");
         $finish;
      end
   end

   function automatic void clear_sequence();
      foreach (model_history[i]) model_history[i] = '0;
      model_seen = '0;
   endfunction

   // weighted stencil sum, scaled, rounded half away from zero and saturated
   function automatic epcd_pkg::scale_res_type stencil_derivative(
      input logic signed [epcd_pkg::SAMPLE_W-1:0] newest);
      longint                  sum;
      longint unsigned         mag;
      longint unsigned         p_hi;
      longint unsigned         p_lo;
      longint unsigned         lim;
      longint unsigned         r;
      logic [63:0]             signed_r;
      logic                    neg;
      epcd_pkg::scale_res_type res;
      sum = 3 * longint'(model_history[7]) - 32 * longint'(model_history[6])
          + 168 * longint'(model_history[5]) - 672 * longint'(model_history[4])
          + 672 * longint'(model_history[2]) - 168 * longint'(model_history[1])
          + 32 * longint'(model_history[0]) - 3 * longint'(newest);
      neg  = (sum < 0);
      mag  = neg ? longint'(0) - sum : sum;
      p_hi = (mag >> 32) * longint'({32'd0, model_scale});
      p_lo = (mag & 64'h0000_0000_FFFF_FFFF) * longint'({32'd0, model_scale});
      lim  = neg ? MAG_NEG_LIMIT : MAG_POS_LIMIT;
      res.clipped = 1'b0;
      if (p_hi >= HI_PRODUCT_LIMIT) begin
         r = lim;
         res.clipped = 1'b1;
      end else begin
         r = (p_hi << 16) + ((p_lo + 64'd32768) >> 16);
         if (r > lim) begin
            r = lim;
            res.clipped = 1'b1;
         end
      end
      signed_r = neg ? (64'd0 - r) : r;
      res.derivative = signed_r[epcd_pkg::DER_W-1:0];
      return res;
   endfunction

   function automatic void push_derivative(input logic [epcd_pkg::DER_W-1:0] value,
                                           input logic clip, input logic last);
      epcd_pkg::rsp_type e;
      e.derivative  = value;
      e.clipped     = clip;
      e.last_result = last;
      pending_derivatives.push_back(e);
   endfunction

   // expected responses for one accepted request transaction
   function automatic void predict_derivatives(input epcd_pkg::req_type item);
      epcd_pkg::scale_res_type calc;
      int                      seen;
      int                      total;
      int                      k;
      seen = int'(model_seen);
      calc = '0;
      if (seen >= 2 * epcd_pkg::EDGE) calc = stencil_derivative(item.sample);
      if (!item.is_last) begin
         if (seen >= epcd_pkg::EDGE) push_derivative(calc.derivative, calc.clipped, 1'b0);
         for (int i = epcd_pkg::TAPS - 1; i > 0; i--) model_history[i] = model_history[i-1];
         model_history[0] = item.sample;
         if (model_seen != 4'd15) model_seen = model_seen + 4'd1;
      end else begin
         // flush: pending position, then trailing zeros up to the sequence length
         total = (seen + 1 < 5) ? seen + 1 : 5;
         k = 0;
         if (seen >= epcd_pkg::EDGE) begin
            push_derivative(calc.derivative, calc.clipped, total == 1);
            k = 1;
         end
         while (k < total) begin
            push_derivative('0, 1'b0, k == total - 1);
            k++;
         end
         clear_sequence();
         sequences_done++;
      end
   endfunction

   // one request transaction, with random idle cycles ahead of it
   task automatic send_sample(input logic signed [epcd_pkg::SAMPLE_W-1:0] value,
                              input logic last);
      epcd_pkg::req_type item;
      item.sample  = value;
      item.is_last = last;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      predict_derivatives(item);
      samples_sent++;
   endtask

   // stop sending until every predicted result has arrived
   task automatic wait_results(input int settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_derivatives.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_scale(input logic [epcd_pkg::SCALE_W-1:0] value);
      wait_results(PIPE_SETTLE);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_scale = value;
      scale_writes++;
   endtask

   function automatic logic signed [epcd_pkg::SAMPLE_W-1:0] pick_sample();
      logic signed [epcd_pkg::SAMPLE_W-1:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = $urandom;
         4, 5, 6:    v = $signed($urandom_range(4000)) - 2000;
         7:          v = SAMPLE_MAX;
         8:          v = SAMPLE_MIN;
         default:    v = $urandom_range(1) ? '1 : '0;
      endcase
      return v;
   endfunction

   // sequences shorter than nine only reach the edge handling
   task automatic test_short_sequences();
      int lengths [4] = '{1, 3, 4, 5};
      foreach (lengths[j]) begin
         for (int i = 0; i < lengths[j]; i++) begin
            send_sample((i % 2) ? SAMPLE_MIN : SAMPLE_MAX, i == lengths[j] - 1);
         end
      end
   endtask

   // alternating extremes give the largest sums of both signs
   task automatic test_saturation();
      logic signed [epcd_pkg::SAMPLE_W-1:0] pattern [11] = '{SAMPLE_MAX, SAMPLE_MIN,
         SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX,
         SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN};
      write_scale(32'hFFFF_FFFF);
      foreach (pattern[i]) send_sample(pattern[i], i == 10);
   endtask

   // random sequences, mostly long enough to reach the full stencil
   task automatic test_random_streams(input int idle_pct, input int stall_pct,
                                      input logic [epcd_pkg::SCALE_W-1:0] scale,
                                      input int budget);
      int  sent;
      int  len;
      int  pick;
      bit  paused;
      write_scale(scale);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent   = 0;
      paused = 1'b0;
      while (sent < budget) begin
         pick = $urandom_range(9);
         if (pick < 6)      len = $urandom_range(20, 9);
         else if (pick < 8) len = $urandom_range(40, 21);
         else               len = $urandom_range(8, 1);
         for (int i = 0; i < len; i++) begin
            send_sample(pick_sample(), i == len - 1);
            sent++;
            // hold off mid sequence until the block has drained
            if (!paused && sent >= budget / 2) begin
               wait_results(0);
               paused = 1'b1;
            end
         end
      end
   endtask

   initial begin
      model_scale = epcd_pkg::SCALE_RESET;
      clear_sequence();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_sequences();
      test_saturation();
      test_random_streams(0, 0, epcd_pkg::SCALE_RESET, 60);
      test_random_streams(75, 0, 32'd0, 60);
      test_random_streams(0, 75, $urandom, 60);
      test_random_streams(25, 25, $urandom_range(32'h0040_0000, 1), 60);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      wait_results(PIPE_SETTLE);

      $display("sent %0d samples in %0d sequences, checked %0d derivatives",
               samples_sent, sequences_done, results_checked);
      $display("%0d scale settings, four idle and stall mixes, %0d mismatches",
               scale_writes + 1, mismatches);
      if (mismatches == 0) begin
         $display("eight_point_central_differentiator regression: pass");
      end else begin
         $display("eight_point_central_differentiator regression: fail");
      end
      $finish;
   end

endmodule
